// ===== hdl/stok_pkg.sv =====
// ----------------------------------------------------------------------------
// stok_pkg
// Shared constants, token kinds and character classes for the source
// tokenizer.
// ----------------------------------------------------------------------------
package stok_pkg;

   // default counter widths
   localparam int LINE_BITS_DEF   = 16;
   localparam int OFFSET_BITS_DEF = 24;
   localparam int LENGTH_BITS_DEF = 16;

   localparam int KIND_BITS  = 4;
   localparam int CHAR_BITS  = 8;

   // result queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   typedef logic [KIND_BITS-1:0] kind_type;
   typedef logic [CHAR_BITS-1:0] char_type;

   // token kinds
   localparam kind_type KIND_LET        = 4'd0;
   localparam kind_type KIND_IDENT      = 4'd1;
   localparam kind_type KIND_INTEGER    = 4'd2;
   localparam kind_type KIND_ASSIGN     = 4'd3;
   localparam kind_type KIND_PLUS       = 4'd4;
   localparam kind_type KIND_MINUS      = 4'd5;
   localparam kind_type KIND_STAR       = 4'd6;
   localparam kind_type KIND_SLASH      = 4'd7;
   localparam kind_type KIND_LPAREN     = 4'd8;
   localparam kind_type KIND_RPAREN     = 4'd9;
   localparam kind_type KIND_COMMA      = 4'd10;
   localparam kind_type KIND_SEMI       = 4'd11;
   localparam kind_type KIND_END        = 4'd12;
   localparam kind_type KIND_BAD_NUMBER = 4'd13;
   localparam kind_type KIND_UNEXPECTED = 4'd14;

   // character codes
   localparam char_type CH_TAB    = 8'h09;
   localparam char_type CH_CR     = 8'h0D;
   localparam char_type CH_NL     = 8'h0A;
   localparam char_type CH_SPACE  = 8'h20;
   localparam char_type CH_UNDER  = 8'h5F;
   localparam char_type CH_SLASH  = 8'h2F;
   localparam char_type CH_EQUAL  = 8'h3D;
   localparam char_type CH_PLUS   = 8'h2B;
   localparam char_type CH_MINUS  = 8'h2D;
   localparam char_type CH_STAR   = 8'h2A;
   localparam char_type CH_LPAREN = 8'h28;
   localparam char_type CH_RPAREN = 8'h29;
   localparam char_type CH_COMMA  = 8'h2C;
   localparam char_type CH_SEMI   = 8'h3B;
   localparam char_type CH_L      = 8'h6C;
   localparam char_type CH_E      = 8'h65;
   localparam char_type CH_T      = 8'h74;
   localparam char_type CH_0      = 8'h30;
   localparam char_type CH_9      = 8'h39;
   localparam char_type CH_UC_A   = 8'h41;
   localparam char_type CH_UC_Z   = 8'h5A;
   localparam char_type CH_LC_A   = 8'h61;
   localparam char_type CH_LC_Z   = 8'h7A;

   function automatic logic is_space(char_type c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   function automatic logic is_digit(char_type c);
      return (c >= CH_0) && (c <= CH_9);
   endfunction

   function automatic logic is_id_start(char_type c);
      return ((c >= CH_UC_A) && (c <= CH_UC_Z)) ||
             ((c >= CH_LC_A) && (c <= CH_LC_Z)) || (c == CH_UNDER);
   endfunction

   function automatic logic is_id_part(char_type c);
      return is_id_start(c) || is_digit(c);
   endfunction

   // single-character tokens; anything else is unexpected
   function automatic kind_type single_kind(char_type c);
      kind_type k;
      unique case (c)
         CH_EQUAL:  k = KIND_ASSIGN;
         CH_PLUS:   k = KIND_PLUS;
         CH_MINUS:  k = KIND_MINUS;
         CH_STAR:   k = KIND_STAR;
         CH_LPAREN: k = KIND_LPAREN;
         CH_RPAREN: k = KIND_RPAREN;
         CH_COMMA:  k = KIND_COMMA;
         CH_SEMI:   k = KIND_SEMI;
         default:   k = KIND_UNEXPECTED;
      endcase
      return k;
   endfunction

endpackage

// ===== hdl/stok_scan.sv =====
// ----------------------------------------------------------------------------
// stok_scan
// Scanner state and per-byte token formation. Each accepted word yields up
// to two packed result words for the result queue.
// ----------------------------------------------------------------------------
module stok_scan
   import stok_pkg::*;
#(
   parameter int LINE_BITS   = LINE_BITS_DEF,
   parameter int OFFSET_BITS = OFFSET_BITS_DEF,
   parameter int LENGTH_BITS = LENGTH_BITS_DEF,
   parameter int WORD_BITS   = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 take_word,
   input  logic                 cmd_end,
   input  char_type             char_byte,
   output logic [1:0]           push_count,
   output logic [WORD_BITS:0]   push_word0,   // {last, data}
   output logic [WORD_BITS:0]   push_word1
);

   localparam int LINE_LSB   = KIND_BITS;
   localparam int OFFSET_LSB = LINE_LSB + LINE_BITS;
   localparam int LENGTH_LSB = OFFSET_LSB + OFFSET_BITS;

   // scan modes
   localparam logic [2:0] MODE_IDLE    = 3'd0;
   localparam logic [2:0] MODE_IDENT   = 3'd1;
   localparam logic [2:0] MODE_NUMBER  = 3'd2;
   localparam logic [2:0] MODE_SLASH   = 3'd3;
   localparam logic [2:0] MODE_COMMENT = 3'd4;
   localparam logic [2:0] MODE_ERROR   = 3'd5;

   // keyword match progress
   localparam logic [2:0] KW_START = 3'd0;
   localparam logic [2:0] KW_L     = 3'd1;
   localparam logic [2:0] KW_LE    = 3'd2;
   localparam logic [2:0] KW_LET   = 3'd3;
   localparam logic [2:0] KW_NONE  = 3'd4;

   logic [2:0]             mode_ff, mode_in;
   logic [LINE_BITS-1:0]   line_ff, line_in;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   logic [OFFSET_BITS-1:0] start_ff, start_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in;
   logic [2:0]             kw_ff, kw_in;

   logic [LINE_BITS-1:0]   line_inc;
   logic [OFFSET_BITS-1:0] offset_inc;
   logic [LENGTH_BITS-1:0] len_inc;

   // fresh-byte handling
   logic [2:0]             fr_mode;
   logic [LINE_BITS-1:0]   fr_line;
   logic [OFFSET_BITS-1:0] fr_start;
   logic [LENGTH_BITS-1:0] fr_len;
   logic [2:0]             fr_kw;
   logic                   fr_emit;
   kind_type               fr_kind;

   // pending run flush
   logic                   fl_valid;
   kind_type               fl_kind;

   // two result slots
   logic                   a_valid, b_valid;
   kind_type               a_kind, b_kind;
   logic [OFFSET_BITS-1:0] a_start, b_start;
   logic [LENGTH_BITS-1:0] a_len, b_len;

   function automatic logic [WORD_BITS:0] pack_word(
      kind_type k, logic [LINE_BITS-1:0] ln, logic [OFFSET_BITS-1:0] st,
      logic [LENGTH_BITS-1:0] lg, logic lst);
      logic [WORD_BITS:0] w;
      w = '0;
      w[KIND_BITS-1:0]                   = k;
      w[OFFSET_LSB-1:LINE_LSB]           = ln;
      w[LENGTH_LSB-1:OFFSET_LSB]         = st;
      w[LENGTH_LSB+LENGTH_BITS-1:LENGTH_LSB] = lg;
      w[WORD_BITS]                       = lst;
      return w;
   endfunction

   assign line_inc   = (line_ff == '1)   ? line_ff   : line_ff + 1'b1;
   assign offset_inc = (offset_ff == '1) ? offset_ff : offset_ff + 1'b1;
   assign len_inc    = (len_ff == '1)    ? len_ff    : len_ff + 1'b1;

   always_comb begin
      fr_mode  = MODE_IDLE;
      fr_line  = line_ff;
      fr_start = start_ff;
      fr_len   = len_ff;
      fr_kw    = kw_ff;
      fr_emit  = 1'b0;
      fr_kind  = KIND_UNEXPECTED;
      if (is_space(char_byte)) begin
         if (char_byte == CH_NL) fr_line = line_inc;
      end else if (char_byte == CH_SLASH) begin
         fr_mode  = MODE_SLASH;
         fr_start = offset_ff;
         fr_len   = LENGTH_BITS'(1);
      end else if (is_id_start(char_byte)) begin
         fr_mode  = MODE_IDENT;
         fr_start = offset_ff;
         fr_len   = LENGTH_BITS'(1);
         fr_kw    = (char_byte == CH_L) ? KW_L : KW_NONE;
      end else if (is_digit(char_byte)) begin
         fr_mode  = MODE_NUMBER;
         fr_start = offset_ff;
         fr_len   = LENGTH_BITS'(1);
      end else begin
         fr_emit = 1'b1;
         fr_kind = single_kind(char_byte);
         if (fr_kind == KIND_UNEXPECTED) fr_mode = MODE_ERROR;
      end
   end

   always_comb begin
      fl_valid = 1'b1;
      fl_kind  = KIND_SLASH;
      unique case (mode_ff)
         MODE_IDENT:  fl_kind = (kw_ff == KW_LET) ? KIND_LET : KIND_IDENT;
         MODE_NUMBER: fl_kind = KIND_INTEGER;
         MODE_SLASH:  fl_kind = KIND_SLASH;
         default:     fl_valid = 1'b0;
      endcase
   end

   always_comb begin
      mode_in   = mode_ff;
      line_in   = line_ff;
      offset_in = offset_ff;
      start_in  = start_ff;
      len_in    = len_ff;
      kw_in     = kw_ff;
      a_valid   = 1'b0;
      a_kind    = fl_kind;
      a_start   = start_ff;
      a_len     = len_ff;
      b_valid   = 1'b0;
      b_kind    = fr_kind;
      b_start   = offset_ff;
      b_len     = LENGTH_BITS'(1);
      if (take_word) begin
         if (cmd_end) begin
            // flush, end token, then back to the reset state
            a_valid   = fl_valid;
            b_valid   = 1'b1;
            b_kind    = KIND_END;
            b_len     = '0;
            mode_in   = MODE_IDLE;
            line_in   = LINE_BITS'(1);
            offset_in = '0;
            start_in  = '0;
            len_in    = '0;
            kw_in     = KW_START;
         end else begin
            unique case (mode_ff)
               MODE_ERROR: begin
               end
               MODE_COMMENT: begin
                  if (char_byte == CH_NL) begin
                     line_in = line_inc;
                     mode_in = MODE_IDLE;
                  end
               end
               MODE_IDENT: begin
                  if (is_id_part(char_byte)) begin
                     len_in = len_inc;
                     if (kw_ff == KW_L && char_byte == CH_E) kw_in = KW_LE;
                     else if (kw_ff == KW_LE && char_byte == CH_T) kw_in = KW_LET;
                     else kw_in = KW_NONE;
                  end else begin
                     a_valid  = 1'b1;
                     b_valid  = fr_emit;
                     mode_in  = fr_mode;
                     line_in  = fr_line;
                     start_in = fr_start;
                     len_in   = fr_len;
                     kw_in    = fr_kw;
                  end
               end
               MODE_NUMBER: begin
                  if (is_digit(char_byte)) begin
                     len_in = len_inc;
                  end else if (is_id_start(char_byte)) begin
                     // length counts the offending character
                     a_valid = 1'b1;
                     a_kind  = KIND_BAD_NUMBER;
                     a_len   = len_inc;
                     mode_in = MODE_ERROR;
                  end else begin
                     a_valid  = 1'b1;
                     b_valid  = fr_emit;
                     mode_in  = fr_mode;
                     line_in  = fr_line;
                     start_in = fr_start;
                     len_in   = fr_len;
                     kw_in    = fr_kw;
                  end
               end
               MODE_SLASH: begin
                  if (char_byte == CH_SLASH) begin
                     mode_in = MODE_COMMENT;
                  end else begin
                     a_valid  = 1'b1;
                     b_valid  = fr_emit;
                     mode_in  = fr_mode;
                     line_in  = fr_line;
                     start_in = fr_start;
                     len_in   = fr_len;
                     kw_in    = fr_kw;
                  end
               end
               default: begin
                  b_valid  = fr_emit;
                  mode_in  = fr_mode;
                  line_in  = fr_line;
                  start_in = fr_start;
                  len_in   = fr_len;
                  kw_in    = fr_kw;
               end
            endcase
            if (mode_in != MODE_ERROR) offset_in = offset_inc;
         end
      end
   end

   // results all carry the line number from before this word
   always_comb begin
      push_count = {1'b0, a_valid} + {1'b0, b_valid};
      push_word1 = pack_word(b_kind, line_ff, b_start, b_len, 1'b1);
      if (a_valid) begin
         push_word0 = pack_word(a_kind, line_ff, a_start, a_len, ~b_valid);
      end else begin
         push_word0 = push_word1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         line_ff   <= LINE_BITS'(1);
         offset_ff <= '0;
         start_ff  <= '0;
         len_ff    <= '0;
         kw_ff     <= KW_START;
      end else begin
         mode_ff   <= mode_in;
         line_ff   <= line_in;
         offset_ff <= offset_in;
         start_ff  <= start_in;
         len_ff    <= len_in;
         kw_ff     <= kw_in;
      end
   end

endmodule

// ===== hdl/stok_rspq.sv =====
// ----------------------------------------------------------------------------
// stok_rspq
// Small result queue: up to two words in, one out (on rsp_tready) per cycle.
// ----------------------------------------------------------------------------
module stok_rspq
   import stok_pkg::*;
#(
   parameter int WORD_BITS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           push_count,
   input  logic [WORD_BITS:0]   push_word0,
   input  logic [WORD_BITS:0]   push_word1,
   output logic                 room_for_two,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [WORD_BITS-1:0] rsp_tdata,
   output logic                 rsp_tlast
);

   logic [WORD_BITS:0]   q_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;
   logic [QPTR_BITS-1:0] wr_ptr_next;
   logic                 pop;

   assign pop          = rsp_tvalid & rsp_tready;
   assign rsp_tvalid   = (count_ff != '0);
   assign room_for_two = (count_ff <= QCNT_BITS'(QUEUE_DEPTH - 2));
   assign rsp_tdata    = q_ff[rd_ptr_ff][WORD_BITS-1:0];
   assign rsp_tlast    = q_ff[rd_ptr_ff][WORD_BITS];
   assign wr_ptr_next  = wr_ptr_ff + 1'b1;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_BITS'(push_count);
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_BITS'(push_count) - QCNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) q_ff[wr_ptr_ff] <= push_word0;
      if (push_count == 2'd2) q_ff[wr_ptr_next] <= push_word1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hdl/source_tokenizer.sv =====
// ----------------------------------------------------------------------------
// source_tokenizer
// Byte-serial lexical tokenizer: source bytes in, tokens out with kind, line,
// start offset and length.
// ----------------------------------------------------------------------------
// One source byte (or end-of-source command, req_tuser high) is taken per
// clock while req_tready is high. Each word yields zero, one or two tokens;
// the scanner forms them in the cycle the word is taken and writes them into
// a four-word result queue, and rsp_tlast marks the last token caused by that
// word. The queue drains one token per cycle while rsp_tready is high, so the
// sustained rate is one input word per cycle while words yield at most one
// token each; a two-token word adds a token to drain. req_tready is high
// whenever the queue has room for two tokens, independent of rsp_tready in
// the same cycle. After an unexpected character or a malformed number, bytes
// are dropped until end of source. No start-up sequence after reset.
// ----------------------------------------------------------------------------
module source_tokenizer
   import stok_pkg::*;
#(
   parameter int LINE_BITS   = LINE_BITS_DEF,
   parameter int OFFSET_BITS = OFFSET_BITS_DEF,
   parameter int LENGTH_BITS = LENGTH_BITS_DEF,
   localparam int RSP_BITS   = KIND_BITS + LINE_BITS + OFFSET_BITS + LENGTH_BITS,
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // char_byte
   input  logic                  req_tuser,   // cmd: 1 = end of source
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // token_kind, line_number, start_offset, token_length, zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast    // last_of_run
);

   logic                  take_word;
   logic [1:0]            push_count;
   logic [RSP_DATA_W:0]   push_word0;
   logic [RSP_DATA_W:0]   push_word1;

   assign take_word = req_tvalid & req_tready;

   stok_scan #(
      .LINE_BITS   (LINE_BITS),
      .OFFSET_BITS (OFFSET_BITS),
      .LENGTH_BITS (LENGTH_BITS),
      .WORD_BITS   (RSP_DATA_W)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .take_word  (take_word),
      .cmd_end    (req_tuser),
      .char_byte  (req_tdata),
      .push_count (push_count),
      .push_word0 (push_word0),
      .push_word1 (push_word1)
   );

   stok_rspq #(
      .WORD_BITS (RSP_DATA_W)
   ) u_rspq (
      .clock        (clock),
      .reset        (reset),
      .push_count   (push_count),
      .push_word0   (push_word0),
      .push_word1   (push_word1),
      .room_for_two (req_tready),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast)
   );

endmodule
